// ===== hw/rtl/amx_pkg.sv =====
// amx_pkg: shared types and constants of the affine matrix inverse
// row control word, row codes and adjugate operand index tables
// no dependencies
package amx_pkg;

    localparam logic [1:0] ROW_CONST = 2'd3;

    typedef struct packed {
        logic [1:0] row;
        logic       singular;
        logic       last;
    } amx_row_t;

    // adjugate entry k = r[P0]*r[P1] - r[N0]*r[N1], row-major indexes
    localparam int ADJ_P0 [9] = '{4, 7, 1, 5, 8, 2, 3, 6, 0};
    localparam int ADJ_P1 [9] = '{8, 2, 5, 6, 0, 3, 7, 1, 4};
    localparam int ADJ_N0 [9] = '{5, 8, 2, 3, 6, 0, 4, 7, 1};
    localparam int ADJ_N1 [9] = '{7, 1, 4, 8, 2, 5, 6, 0, 3};

endpackage

// ===== hw/rtl/amx_front.sv =====
// amx_front: six-stage pipeline for adjugate, determinant and inverse translation sums
// depends on amx_pkg for the adjugate operand tables
module amx_front import amx_pkg::*; #(
    parameter int W = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic signed [W-1:0]   lin [9],
    input  logic signed [W-1:0]   shift [3],
    output logic                  out_valid,
    output logic signed [2*W:0]   adj [9],
    output logic signed [3*W+3:0] t_neg [3],
    output logic signed [3*W+3:0] det
);
    localparam int PW = 2 * W;
    localparam int AW = 2 * W + 1;
    localparam int TW = 3 * W + 1;
    localparam int NW = 3 * W + 4;

    logic [5:0]           vld_reg;
    logic signed [W-1:0]  r_reg [9];
    logic signed [W-1:0]  v_reg [3];
    logic signed [W-1:0]  c1_reg [3];
    logic signed [W-1:0]  v1_reg [3];
    logic signed [W-1:0]  c2_reg [3];
    logic signed [W-1:0]  v2_reg [3];
    logic signed [PW-1:0] pa_reg [9];
    logic signed [PW-1:0] pb_reg [9];
    logic signed [AW-1:0] adj2_reg [9];
    logic signed [AW-1:0] adj3_reg [9];
    logic signed [AW-1:0] adj4_reg [9];
    logic signed [AW-1:0] adj5_reg [9];
    logic signed [AW-1:0] lo_reg [12];
    logic signed [AW-1:0] hi_reg [12];
    logic signed [TW-1:0] term_reg [12];
    logic signed [NW-1:0] det_reg;
    logic signed [NW-1:0] t_reg [3];
    logic signed [W-1:0]  fac [12];
    logic signed [AW-1:0] opd [12];

    // determinant terms first, then translation terms row by row
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            fac[k] = c2_reg[k];
            opd[k] = adj2_reg[k];
        end
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                fac[3 + 3 * i + j] = v2_reg[j];
                opd[3 + 3 * i + j] = adj2_reg[3 * i + j];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg <= lin;
            v_reg <= shift;
            for (int k = 0; k < 9; k++)
            begin
                pa_reg[k]   <= r_reg[ADJ_P0[k]] * r_reg[ADJ_P1[k]];
                pb_reg[k]   <= r_reg[ADJ_N0[k]] * r_reg[ADJ_N1[k]];
                adj2_reg[k] <= AW'(pa_reg[k]) - AW'(pb_reg[k]);
            end
            for (int k = 0; k < 3; k++)
            begin
                c1_reg[k] <= r_reg[3 * k];
            end
            v1_reg   <= v_reg;
            c2_reg   <= c1_reg;
            v2_reg   <= v1_reg;
            adj3_reg <= adj2_reg;
            adj4_reg <= adj3_reg;
            adj5_reg <= adj4_reg;
            for (int m = 0; m < 12; m++)
            begin
                lo_reg[m]   <= fac[m] * $signed({1'b0, opd[m][W-1:0]});
                hi_reg[m]   <= fac[m] * $signed(opd[m][AW-1:W]);
                term_reg[m] <= (TW'(hi_reg[m]) <<< W) + TW'(lo_reg[m]);
            end
            det_reg <= NW'(term_reg[0]) + NW'(term_reg[1]) + NW'(term_reg[2]);
            for (int i = 0; i < 3; i++)
            begin
                t_reg[i] <= -(NW'(term_reg[3 + 3 * i]) + NW'(term_reg[4 + 3 * i])
                              + NW'(term_reg[5 + 3 * i]));
            end
        end
    end

    assign out_valid = vld_reg[5];
    assign adj       = adj5_reg;
    assign t_neg     = t_reg;
    assign det       = det_reg;

endmodule

// ===== hw/rtl/amx_rowseq.sv =====
// amx_rowseq: holds one finished matrix and issues its four rows, one per cycle
// while en is high; depends on amx_pkg for the row control word
module amx_rowseq import amx_pkg::*; #(
    parameter int W = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  load_valid,
    input  logic signed [2*W:0]   adj_in [9],
    input  logic signed [3*W+3:0] t_in [3],
    input  logic signed [3*W+3:0] det_in,
    output logic                  free,
    output logic                  issue_valid,
    output logic signed [3*W+3:0] num [4],
    output logic signed [3*W+3:0] den,
    output amx_row_t              ctl
);
    localparam int AW = 2 * W + 1;
    localparam int NW = 3 * W + 4;

    logic                 hold_vld_reg;
    logic [1:0]           cnt_reg;
    logic                 sing_reg;
    logic signed [AW-1:0] adj_reg [9];
    logic signed [NW-1:0] t_reg [3];
    logic signed [NW-1:0] det_reg;
    logic                 last_issue;

    assign last_issue = en && hold_vld_reg && (cnt_reg == ROW_CONST);
    assign free       = !hold_vld_reg || last_issue;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_vld_reg <= 1'b0;
            cnt_reg      <= '0;
        end
        else if (free)
        begin
            hold_vld_reg <= load_valid;
            cnt_reg      <= '0;
        end
        else if (en)
        begin
            cnt_reg <= cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free && load_valid)
        begin
            adj_reg  <= adj_in;
            t_reg    <= t_in;
            det_reg  <= det_in;
            sing_reg <= (det_in == '0);
        end
    end

    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            num[j] = '0;
        end
        case (cnt_reg)
            2'd0:
            begin
                for (int j = 0; j < 3; j++)
                begin
                    num[j] = NW'(adj_reg[j]);
                end
                num[3] = t_reg[0];
            end
            2'd1:
            begin
                for (int j = 0; j < 3; j++)
                begin
                    num[j] = NW'(adj_reg[3 + j]);
                end
                num[3] = t_reg[1];
            end
            2'd2:
            begin
                for (int j = 0; j < 3; j++)
                begin
                    num[j] = NW'(adj_reg[6 + j]);
                end
                num[3] = t_reg[2];
            end
            default:
            begin
            end
        endcase
    end

    assign issue_valid  = hold_vld_reg;
    assign den          = det_reg;
    assign ctl.row      = cnt_reg;
    assign ctl.singular = sing_reg;
    assign ctl.last     = (cnt_reg == ROW_CONST);

endmodule

// ===== hw/rtl/amx_div.sv =====
// amx_div: pipelined restoring divider for one column, rounded and clipped to a word
// computes round(n * 2^SH / d) one quotient bit per stage; no dependencies
module amx_div #(
    parameter int W  = 32,
    parameter int NW = 100,
    parameter int SH = 32
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [NW-1:0] n,
    input  logic signed [NW-1:0] d,
    output logic [W-1:0]         q,
    output logic                 sat
);
    localparam int NB = NW + SH + 2;
    localparam int DV = NW + 1;
    localparam logic [W-1:0] HALF = {1'b1, {(W-1){1'b0}}};

    logic [NW-1:0] mag_reg;
    logic [NW-1:0] ad_reg;
    logic          nega_reg;
    logic [NB-1:0] numb_reg;
    logic [DV-1:0] dvb_reg;
    logic          negb_reg;
    logic [NB-1:0] rem_reg [W];
    logic [DV-1:0] dv_reg [W];
    logic [W-1:0]  qs_reg [W+1];
    logic          neg_reg [W+1];
    logic          ovf_reg [W+1];
    logic [W-1:0]  q_reg;
    logic          sat_reg;
    logic [W-1:0]  lim;
    logic          clip;
    logic [W-1:0]  qc;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg    <= n[NW-1] ? NW'(-n) : NW'(n);
            ad_reg     <= d[NW-1] ? NW'(-d) : NW'(d);
            nega_reg   <= n[NW-1] ^ d[NW-1];
            numb_reg   <= (NB'(mag_reg) << (SH + 1)) + NB'(ad_reg);
            dvb_reg    <= DV'(ad_reg) << 1;
            negb_reg   <= nega_reg;
            rem_reg[0] <= numb_reg;
            dv_reg[0]  <= dvb_reg;
            qs_reg[0]  <= '0;
            neg_reg[0] <= negb_reg;
            ovf_reg[0] <= (numb_reg >> W) >= NB'(dvb_reg);
        end
    end

    for (genvar k = 0; k < W; k++)
    begin : g_step
        localparam int B = W - 1 - k;
        logic ge;
        assign ge = (rem_reg[k] >> B) >= NB'(dv_reg[k]);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                qs_reg[k+1]  <= qs_reg[k] | (ge ? (W'(1) << B) : '0);
                neg_reg[k+1] <= neg_reg[k];
                ovf_reg[k+1] <= ovf_reg[k];
            end
        end
        if (k < W - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k+1] <= ge ? rem_reg[k] - (NB'(dv_reg[k]) << B) : rem_reg[k];
                    dv_reg[k+1]  <= dv_reg[k];
                end
            end
        end
    end

    assign lim  = neg_reg[W] ? HALF : HALF - W'(1);
    assign clip = ovf_reg[W] || (qs_reg[W] > lim);
    assign qc   = clip ? lim : qs_reg[W];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg   <= neg_reg[W] ? -qc : qc;
            sat_reg <= clip;
        end
    end

    assign q   = q_reg;
    assign sat = sat_reg;

endmodule

// ===== hw/rtl/affine_matrix_inverse.sv =====
// affine_matrix_inverse: inverse of a 3x4 affine transform in signed fixed point
// uses amx_pkg, amx_front, amx_rowseq and amx_div
//
// One transfer on the item channel (item_valid/item_ready) carries the nine
// linear entries and three translation entries. The row channel
// (row_valid/row_ready) then returns four rows in order: three inverse rows
// and the constant row 0,0,0,1.0 with last_row set. A zero determinant gives
// all-zero rows with singular set; clipped entries set saturated.
// The first row passes the front pipeline, the row buffer, the dividers and
// the output register; the other rows follow one per cycle while row_ready
// allows. New matrices enter while earlier ones are in flight, paced by the
// single row channel; rows pass four column dividers of WORD_BITS + 4 stages.
// When row_valid is high and row_ready is low the row side holds; the front
// pipeline keeps moving until its last stage holds a matrix that the buffer
// cannot take, and item_ready stays low while that lasts; nothing is lost.
// Reset clears all valid bits; no rows come out until a new transfer.
module affine_matrix_inverse import amx_pkg::*; #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_ready,
    input  logic signed [WORD_BITS-1:0] lin_00,
    input  logic signed [WORD_BITS-1:0] lin_01,
    input  logic signed [WORD_BITS-1:0] lin_02,
    input  logic signed [WORD_BITS-1:0] lin_10,
    input  logic signed [WORD_BITS-1:0] lin_11,
    input  logic signed [WORD_BITS-1:0] lin_12,
    input  logic signed [WORD_BITS-1:0] lin_20,
    input  logic signed [WORD_BITS-1:0] lin_21,
    input  logic signed [WORD_BITS-1:0] lin_22,
    input  logic signed [WORD_BITS-1:0] shift_0,
    input  logic signed [WORD_BITS-1:0] shift_1,
    input  logic signed [WORD_BITS-1:0] shift_2,
    output logic                        row_valid,
    input  logic                        row_ready,
    output logic [1:0]                  row_index,
    output logic signed [WORD_BITS-1:0] col_0,
    output logic signed [WORD_BITS-1:0] col_1,
    output logic signed [WORD_BITS-1:0] col_2,
    output logic signed [WORD_BITS-1:0] col_3,
    output logic                        singular,
    output logic                        saturated,
    output logic                        last_row
);
    localparam int W   = WORD_BITS;
    localparam int AW  = 2 * W + 1;
    localparam int NW  = 3 * W + 4;
    localparam int LAT = W + 4;
    localparam bit ONE_FITS = (FRAC_BITS < W - 1);
    localparam logic [W-1:0] ONE_WORD = ONE_FITS ? (W'(1) << FRAC_BITS)
                                                 : {1'b0, {(W-1){1'b1}}};

    logic                 adv;
    logic                 front_adv;
    logic                 front_vld;
    logic                 seq_free;
    logic                 seq_vld;
    logic signed [W-1:0]  lin_arr [9];
    logic signed [W-1:0]  shift_arr [3];
    logic signed [AW-1:0] adj [9];
    logic signed [NW-1:0] t_neg [3];
    logic signed [NW-1:0] det;
    logic signed [NW-1:0] num [4];
    logic signed [NW-1:0] den;
    amx_row_t             seq_ctl;
    logic [W-1:0]         q_col [4];
    logic                 sat_col [4];
    logic                 vld_pipe_reg [LAT];
    amx_row_t             ctl_pipe_reg [LAT];
    amx_row_t             ctl_end;
    logic                 row_valid_reg;
    logic [1:0]           row_index_reg;
    logic [W-1:0]         col_reg [4];
    logic                 singular_reg;
    logic                 saturated_reg;
    logic                 last_row_reg;

    assign adv        = !row_valid_reg || row_ready;
    assign front_adv  = seq_free || !front_vld;
    assign item_ready = front_adv;

    assign lin_arr   = '{lin_00, lin_01, lin_02, lin_10, lin_11, lin_12,
                         lin_20, lin_21, lin_22};
    assign shift_arr = '{shift_0, shift_1, shift_2};

    amx_front #(.W(W)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (front_adv),
        .in_valid  (item_valid),
        .lin       (lin_arr),
        .shift     (shift_arr),
        .out_valid (front_vld),
        .adj       (adj),
        .t_neg     (t_neg),
        .det       (det)
    );

    amx_rowseq #(.W(W)) u_rowseq (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (adv),
        .load_valid  (front_vld),
        .adj_in      (adj),
        .t_in        (t_neg),
        .det_in      (det),
        .free        (seq_free),
        .issue_valid (seq_vld),
        .num         (num),
        .den         (den),
        .ctl         (seq_ctl)
    );

    for (genvar j = 0; j < 4; j++)
    begin : g_col
        amx_div #(
            .W  (W),
            .NW (NW),
            .SH ((j < 3) ? 2 * FRAC_BITS : FRAC_BITS)
        ) u_div (
            .clk (clk),
            .en  (adv),
            .n   (num[j]),
            .d   (den),
            .q   (q_col[j]),
            .sat (sat_col[j])
        );
    end

    // row control travels alongside the divider stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < LAT; s++)
            begin
                vld_pipe_reg[s] <= 1'b0;
            end
            row_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_pipe_reg[0] <= seq_vld;
            for (int s = 1; s < LAT; s++)
            begin
                vld_pipe_reg[s] <= vld_pipe_reg[s-1];
            end
            row_valid_reg <= vld_pipe_reg[LAT-1];
        end
    end

    assign ctl_end = ctl_pipe_reg[LAT-1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctl_pipe_reg[0] <= seq_ctl;
            for (int s = 1; s < LAT; s++)
            begin
                ctl_pipe_reg[s] <= ctl_pipe_reg[s-1];
            end
            row_index_reg <= ctl_end.row;
            singular_reg  <= ctl_end.singular;
            last_row_reg  <= ctl_end.last;
            if (ctl_end.singular)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    col_reg[j] <= '0;
                end
                saturated_reg <= 1'b0;
            end
            else if (ctl_end.row == ROW_CONST)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    col_reg[j] <= '0;
                end
                col_reg[3]    <= ONE_WORD;
                saturated_reg <= ONE_FITS ? 1'b0 : 1'b1;
            end
            else
            begin
                col_reg       <= q_col;
                saturated_reg <= sat_col[0] | sat_col[1] | sat_col[2] | sat_col[3];
            end
        end
    end

    assign row_valid = row_valid_reg;
    assign row_index = row_index_reg;
    assign col_0     = col_reg[0];
    assign col_1     = col_reg[1];
    assign col_2     = col_reg[2];
    assign col_3     = col_reg[3];
    assign singular  = singular_reg;
    assign saturated = saturated_reg;
    assign last_row  = last_row_reg;

endmodule
